// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port check failed: next-cycle property");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port check failed: same-cycle property");

`endif

// ===== rtl/cfir_pkg.sv =====
// Types and constants shared by the complex FIR filter files.
`timescale 1ns / 1ps

package cfir_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int FRAC_W   = 15;
    localparam int INDEX_W  = 6;

    localparam logic MODE_FILTER = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;

    // Per-cell control: shift the delay line, write this cell's weight.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

// ===== rtl/complex_fir_filter_top.sv =====
// Top level of the complex FIR filter: tap cell chain, rounding and output register.
//
//   channel   direction  handshake           payload
//   input     in         i_valid / o_stall   i_mode i_sample_re i_sample_im
//                                            i_coef_index i_coef_value
//   output    out        o_valid / i_stall   o_out_re o_out_im o_clipped
//
// A sample item enters via the start register; its partial sums walk the chain
// of NTAPS tap cells one cell per cycle, then rounding, hold and output registers.
// A weight load writes the addressed tap weight and gives no item on the output.
// Reset clears the delay line and all weights at once; no sweep follows.
// o_stall is high while a sample item is in the chain or its result is held
// behind a full output register; a waiting output item does not block input.
`timescale 1ns / 1ps

module complex_fir_filter_top #(
    parameter int NTAPS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  cfir_pkg::t_sample                   i_sample_re,
    input  cfir_pkg::t_sample                   i_sample_im,
    input  logic [cfir_pkg::INDEX_W-1:0]        i_coef_index,
    input  cfir_pkg::t_coef                     i_coef_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output cfir_pkg::t_sample                   o_out_re,
    output cfir_pkg::t_sample                   o_out_im,
    output logic                                o_clipped
);
    import cfir_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(NTAPS);

    logic                    s_accept;
    logic                    r_busy;
    logic                    r_start;
    t_cell_ctl               s_ctl    [NTAPS];
    t_sample                 w_x_re   [NTAPS+1];
    t_sample                 w_x_im   [NTAPS+1];
    logic                    w_vld    [NTAPS+1];
    logic signed [ACC_W-1:0] w_acc_re [NTAPS+1];
    logic signed [ACC_W-1:0] w_acc_im [NTAPS+1];

    t_sample                 s_rnd_re;
    t_sample                 s_rnd_im;
    logic                    s_clip_re;
    logic                    s_clip_im;

    logic                    r_hold_v;
    t_sample                 r_hold_re;
    t_sample                 r_hold_im;
    logic                    r_hold_clip;
    logic                    s_move;

    logic                    r_out_valid;
    t_sample                 r_out_re;
    t_sample                 r_out_im;
    logic                    r_out_clip;

    assign o_stall  = r_busy;
    assign s_accept = i_valid && !r_busy;

    assign w_x_re[0]   = i_sample_re;
    assign w_x_im[0]   = i_sample_im;
    assign w_vld[0]    = r_start;
    assign w_acc_re[0] = '0;
    assign w_acc_im[0] = '0;

    for (genvar k = 0; k < NTAPS; k++) begin : g_tap
        always_comb begin
            s_ctl[k].shift = s_accept && (i_mode == MODE_FILTER);
            // Taps beyond the index range never match and keep weight zero.
            s_ctl[k].load  = s_accept && (i_mode == MODE_LOAD) && (32'(i_coef_index) == k);
        end

        cfir_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (s_ctl[k]),
            .i_x_re   (w_x_re[k]),
            .i_x_im   (w_x_im[k]),
            .i_w      (i_coef_value),
            .i_vld    (w_vld[k]),
            .i_acc_re (w_acc_re[k]),
            .i_acc_im (w_acc_im[k]),
            .o_x_re   (w_x_re[k+1]),
            .o_x_im   (w_x_im[k+1]),
            .o_vld    (w_vld[k+1]),
            .o_acc_re (w_acc_re[k+1]),
            .o_acc_im (w_acc_im[k+1])
        );
    end

    cfir_round #(
        .ACC_W (ACC_W)
    ) u_round_re (
        .i_acc   (w_acc_re[NTAPS]),
        .o_value (s_rnd_re),
        .o_clip  (s_clip_re)
    );

    cfir_round #(
        .ACC_W (ACC_W)
    ) u_round_im (
        .i_acc   (w_acc_im[NTAPS]),
        .o_value (s_rnd_im),
        .o_clip  (s_clip_im)
    );

    assign s_move = r_hold_v && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= s_accept && (i_mode == MODE_FILTER);
            if (s_accept && (i_mode == MODE_FILTER)) begin
                r_busy <= 1'b1;
            end else if (s_move) begin
                r_busy <= 1'b0;
            end
            if (w_vld[NTAPS]) begin
                r_hold_v <= 1'b1;
            end else if (s_move) begin
                r_hold_v <= 1'b0;
            end
            if (s_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vld[NTAPS]) begin
            r_hold_re   <= s_rnd_re;
            r_hold_im   <= s_rnd_im;
            r_hold_clip <= s_clip_re | s_clip_im;
        end
        if (s_move) begin
            r_out_re   <= r_hold_re;
            r_out_im   <= r_hold_im;
            r_out_clip <= r_hold_clip;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_out_re  = r_out_re;
    assign o_out_im  = r_out_im;
    assign o_clipped = r_out_clip;

endmodule

// ===== rtl/cfir_cell.sv =====
// One tap cell: delay-line slot, tap weight and multiply-accumulate stage.
`timescale 1ns / 1ps

module cfir_cell #(
    parameter int ACC_W = 38
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cfir_pkg::t_cell_ctl     i_ctl,
    input  cfir_pkg::t_sample       i_x_re,
    input  cfir_pkg::t_sample       i_x_im,
    input  cfir_pkg::t_coef         i_w,
    input  logic                    i_vld,
    input  logic signed [ACC_W-1:0] i_acc_re,
    input  logic signed [ACC_W-1:0] i_acc_im,
    output cfir_pkg::t_sample       o_x_re,
    output cfir_pkg::t_sample       o_x_im,
    output logic                    o_vld,
    output logic signed [ACC_W-1:0] o_acc_re,
    output logic signed [ACC_W-1:0] o_acc_im
);
    import cfir_pkg::*;

    t_sample                   r_x_re;
    t_sample                   r_x_im;
    t_coef                     r_w;
    logic                      r_vld;
    logic signed [ACC_W-1:0]   r_acc_re;
    logic signed [ACC_W-1:0]   r_acc_im;
    logic signed [PROD_W-1:0]  s_prod_re;
    logic signed [PROD_W-1:0]  s_prod_im;
    logic signed [ACC_W-1:0]   n_acc_re;
    logic signed [ACC_W-1:0]   n_acc_im;

    always_comb begin
        s_prod_re = r_x_re * r_w;
        s_prod_im = r_x_im * r_w;
        n_acc_re  = i_acc_re + ACC_W'(s_prod_re);
        n_acc_im  = i_acc_im + ACC_W'(s_prod_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_re <= '0;
            r_x_im <= '0;
            r_w    <= '0;
            r_vld  <= 1'b0;
        end else begin
            if (i_ctl.shift) begin
                r_x_re <= i_x_re;
                r_x_im <= i_x_im;
            end
            if (i_ctl.load) begin
                r_w <= i_w;
            end
            r_vld <= i_vld;
        end
    end

    // Partial sums are meaningful only alongside the valid bit.
    always_ff @(posedge i_clk) begin
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    assign o_x_re   = r_x_re;
    assign o_x_im   = r_x_im;
    assign o_vld    = r_vld;
    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

// ===== rtl/cfir_round.sv =====
// Round half up, drop the fraction bits and saturate to a 16-bit sample.
`timescale 1ns / 1ps

module cfir_round #(
    parameter int ACC_W = 38
) (
    input  logic signed [ACC_W-1:0] i_acc,
    output cfir_pkg::t_sample       o_value,
    output logic                    o_clip
);
    import cfir_pkg::*;

    localparam int Q_W = ACC_W + 1 - FRAC_W;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);
    localparam logic signed [ACC_W:0] HALF  = (ACC_W + 1)'(1 << (FRAC_W - 1));

    logic signed [ACC_W:0] s_sum;
    logic signed [Q_W-1:0] s_q;

    always_comb begin
        s_sum = (ACC_W + 1)'(i_acc) + HALF;
        s_q   = signed'(s_sum[ACC_W:FRAC_W]);
        if (s_q > Q_MAX) begin
            o_value = t_sample'(Q_MAX[SAMPLE_W-1:0]);
            o_clip  = 1'b1;
        end else if (s_q < Q_MIN) begin
            o_value = t_sample'(Q_MIN[SAMPLE_W-1:0]);
            o_clip  = 1'b1;
        end else begin
            o_value = t_sample'(s_q[SAMPLE_W-1:0]);
            o_clip  = 1'b0;
        end
    end

endmodule

// ===== rtl/cfir_checker.sv =====
// Port-level checks for the complex FIR filter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfir_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         i_mode,
    input logic                         o_valid,
    input logic                         i_stall,
    input cfir_pkg::t_sample            o_out_re,
    input cfir_pkg::t_sample            o_out_im,
    input logic                         o_clipped
);
    import cfir_pkg::*;

    logic s_full_scale;

    assign s_full_scale = (o_out_re == 16'sh7FFF) || (o_out_re == 16'sh8000) ||
                          (o_out_im == 16'sh7FFF) || (o_out_im == 16'sh8000);

    // A stalled output item stays and holds its payload.
    `ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable({o_out_re, o_out_im, o_clipped}))
    // A sample item occupies the tap chain, so input stalls right after it.
    `ASSERT_NEXT(a_sample_busy, i_valid && !o_stall && (i_mode == MODE_FILTER), o_stall)
    // A weight load leaves the block free for the next item.
    `ASSERT_NEXT(a_load_free, i_valid && !o_stall && (i_mode == MODE_LOAD), !o_stall)
    // A clipped item carries a full-scale value in at least one part.
    `ASSERT_SAME(a_clip_value, o_valid && o_clipped, s_full_scale)

endmodule

bind complex_fir_filter_top cfir_checker u_cfir_checker (.*);

// ===== tb/tb_complex_fir_filter_top.sv =====
// Self-checking testbench for the complex FIR filter: tap loads, samples, random stalls.
`timescale 1ns / 1ps

module tb_complex_fir_filter_top;
    import cfir_pkg::*;

    localparam int     TAPS        = 64;
    localparam int     IDLE_PCT    = 19;
    localparam int     ITEM_TARGET = 1600;
    localparam int     STALL_LIMIT = 4000;
    localparam longint ROUND_HALF  = longint'(1) << (FRAC_W - 1);
    localparam longint SAT_MAX     = 32767;
    localparam longint SAT_MIN     = -32768;

    typedef struct {
        logic                 mode;
        t_sample              sample_re;
        t_sample              sample_im;
        logic [INDEX_W-1:0]   coef_index;
        t_coef                coef_value;
    } t_fir_item;

    typedef struct {
        t_sample re;
        t_sample im;
        logic    clipped;
    } t_fir_result;

    // Tracks delay line and tap weights, predicts each filtered sample.
    class fir_output_scoreboard;
        t_sample     delay_re [TAPS] = '{default: '0};
        t_sample     delay_im [TAPS] = '{default: '0};
        t_coef       tap_weight [TAPS] = '{default: '0};
        int          next_slot = 0;
        int          error_count = 0;
        t_fir_result expected_q [$];

        function t_sample round_saturate(input longint acc, inout logic clip);
            longint q;
            q = (acc + ROUND_HALF) >>> FRAC_W;
            if (q > SAT_MAX) begin
                q = SAT_MAX;
                clip = 1'b1;
            end else if (q < SAT_MIN) begin
                q = SAT_MIN;
                clip = 1'b1;
            end
            return t_sample'(q);
        endfunction

        function void note_input(input t_fir_item it);
            longint      acc_re;
            longint      acc_im;
            int          slot;
            logic        clip;
            t_fir_result res;
            if (it.mode == MODE_LOAD) begin
                // a tap index past the filter length is dropped
                if (int'(it.coef_index) < TAPS)
                    tap_weight[it.coef_index] = it.coef_value;
                return;
            end
            delay_re[next_slot] = it.sample_re;
            delay_im[next_slot] = it.sample_im;
            acc_re = 0;
            acc_im = 0;
            for (int k = 0; k < TAPS; k++) begin
                slot = (next_slot + TAPS - k) % TAPS;
                acc_re += longint'(delay_re[slot]) * longint'(tap_weight[k]);
                acc_im += longint'(delay_im[slot]) * longint'(tap_weight[k]);
            end
            next_slot = (next_slot + 1) % TAPS;
            clip = 1'b0;
            res.re = round_saturate(acc_re, clip);
            res.im = round_saturate(acc_im, clip);
            res.clipped = clip;
            expected_q.push_back(res);
        endfunction

        function void check_result(input t_sample re, input t_sample im, input logic clipped);
            t_fir_result exp_res;
            if (expected_q.size() == 0) begin
                $error("result with none expected: out_re=%0d out_im=%0d clipped=%0b",
                       re, im, clipped);
                error_count++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (re !== exp_res.re) begin
                $error("out_re mismatch: expected %0d, actual %0d", exp_res.re, re);
                error_count++;
            end
            if (im !== exp_res.im) begin
                $error("out_im mismatch: expected %0d, actual %0d", exp_res.im, im);
                error_count++;
            end
            if (clipped !== exp_res.clipped) begin
                $error("clipped mismatch: expected %0b, actual %0b", exp_res.clipped, clipped);
                error_count++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_mode;
    t_sample            i_sample_re;
    t_sample            i_sample_im;
    logic [INDEX_W-1:0] i_coef_index;
    t_coef              i_coef_value;
    logic               o_valid;
    logic               i_stall = 1'b0;
    t_sample            o_out_re;
    t_sample            o_out_im;
    logic               o_clipped;

    fir_output_scoreboard sb;
    int                   items_sent = 0;
    bit                   steady_run = 1'b0;
    int                   idle_cycles = 0;

    complex_fir_filter_top #(.NTAPS(TAPS)) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_sample_re  (i_sample_re),
        .i_sample_im  (i_sample_im),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_re     (o_out_re),
        .o_out_im     (o_out_im),
        .o_clipped    (o_clipped)
    );

    always #5 i_clk = ~i_clk;

    // Output back-pressure; none during the steady stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n || steady_run)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_re, o_out_im, o_clipped);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input t_fir_item it);
        int gap;
        gap = 0;
        if (!steady_run)
            while ($urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_mode       <= it.mode;
        i_sample_re  <= it.sample_re;
        i_sample_im  <= it.sample_im;
        i_coef_index <= it.coef_index;
        i_coef_value <= it.coef_value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_tap(input int idx, input t_coef value);
        t_fir_item it;
        it.mode       = MODE_LOAD;
        it.sample_re  = t_sample'($urandom);
        it.sample_im  = t_sample'($urandom);
        it.coef_index = idx[INDEX_W-1:0];
        it.coef_value = value;
        send_item(it);
    endtask

    task automatic feed_sample(input t_sample re, input t_sample im);
        t_fir_item it;
        it.mode       = MODE_FILTER;
        it.sample_re  = re;
        it.sample_im  = im;
        it.coef_index = INDEX_W'($urandom);
        it.coef_value = t_coef'($urandom);
        send_item(it);
    endtask

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0:       return t_sample'(SAT_MIN);
            1:       return t_sample'(SAT_MAX);
            2:       return '0;
            3, 4:    return t_sample'(int'($urandom_range(0, 1023)) - 512);
            default: return t_sample'($urandom);
        endcase
    endfunction

    // Mostly modest weights so that many sums stay inside the output range.
    function automatic t_coef rand_weight();
        case ($urandom_range(0, 9))
            0, 1:       return '0;
            2:          return t_coef'(SAT_MIN);
            3:          return t_coef'(SAT_MAX);
            4, 5, 6, 7: return t_coef'(int'($urandom_range(0, 4095)) - 2048);
            default:    return t_coef'($urandom);
        endcase
    endfunction

    function automatic int rand_tap_index();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, TAPS - 1);
        return $urandom_range(0, 11);
    endfunction

    initial begin
        int n;
        sb           = new;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_mode       = MODE_FILTER;
        i_sample_re  = '0;
        i_sample_im  = '0;
        i_coef_index = '0;
        i_coef_value = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all weights zero after reset
        feed_sample(t_sample'(SAT_MAX), t_sample'(SAT_MIN));
        // unit weight on tap 0: rounding ties go up
        load_tap(0, t_coef'(1));
        feed_sample(t_sample'(16384), t_sample'(-16384));
        feed_sample(t_sample'(SAT_MIN), t_sample'(SAT_MAX));
        // minus one on tap 0: most negative sample overflows
        load_tap(0, t_coef'(SAT_MIN));
        feed_sample(t_sample'(SAT_MIN), t_sample'(SAT_MAX));
        feed_sample(t_sample'(SAT_MAX), '0);
        // three full-scale taps clip both ways
        load_tap(TAPS - 1, t_coef'(SAT_MAX));
        load_tap(1, t_coef'(SAT_MAX));
        load_tap(0, t_coef'(SAT_MAX));
        feed_sample(t_sample'(SAT_MAX), t_sample'(SAT_MIN));
        feed_sample(t_sample'(SAT_MAX), t_sample'(SAT_MIN));
        feed_sample(t_sample'(SAT_MIN), t_sample'(SAT_MAX));
        feed_sample(t_sample'(SAT_MIN), t_sample'(SAT_MAX));
        // real-only input, then shorten back to a single tap
        feed_sample(t_sample'(12345), '0);
        load_tap(1, '0);
        load_tap(TAPS - 1, '0);
        feed_sample(t_sample'(-1), t_sample'(1));
        feed_sample(t_sample'(SAT_MIN), t_sample'(SAT_MIN));

        while (items_sent < ITEM_TARGET) begin
            steady_run = (items_sent >= 700 && items_sent < 1000);
            // occasionally clear all taps, then set up a short filter
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < TAPS; k++) load_tap(k, '0);
            n = $urandom_range(1, 8);
            repeat (n) load_tap(rand_tap_index(), rand_weight());
            n = $urandom_range(30, 80);
            repeat (n) begin
                if ($urandom_range(0, 19) == 0)
                    load_tap(rand_tap_index(), rand_weight());
                else if ($urandom_range(0, 6) == 0)
                    feed_sample(rand_sample(), '0);
                else
                    feed_sample(rand_sample(), rand_sample());
            end
        end
        steady_run = 1'b0;
        i_valid <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (TAPS + 10) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
